### rtl/core/dbgc_pkg.sv
package dbgc_pkg;

  localparam int NUM_GLYPHS_DEF = 8;
  localparam int LEVEL_MAX_DEF  = 5;

  localparam logic [7:0] CODE_BLANK = 8'd32;
  localparam logic [7:0] CODE_FULL  = 8'd255;
  localparam logic [1:0] AGE_FRESH  = 2'd2;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic       func;
    logic [2:0] left_level;
    logic [2:0] right_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       define_glyph;
    logic [4:0] upper_pattern;
    logic [4:0] lower_pattern;
    logic       no_match;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TICK
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic decide;
    logic tick_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

### rtl/core/dbgc_ctrl.sv
module dbgc_ctrl
  import dbgc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    func,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (func == FUNC_TICK) ? ST_TICK : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_IDLE;
      end
      ST_TICK: begin
        if (status.scan_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ST_TICK: begin
        cmd.tick_step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### rtl/core/dbgc_dp.sv
module dbgc_dp
  import dbgc_pkg::*;
#(
  parameter int NUM_GLYPHS = NUM_GLYPHS_DEF,
  parameter int LEVEL_MAX  = LEVEL_MAX_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t item,
  input  cmd_t     cmd,
  output status_t  status,
  output logic     result_strobe,
  output result_t  result
);

  localparam int IDX_W = (NUM_GLYPHS > 1) ? $clog2(NUM_GLYPHS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_GLYPHS - 1);
  localparam logic [3:0] LMAX4 = 4'(LEVEL_MAX);
  localparam logic [2:0] LMAX3 = 3'(LEVEL_MAX);

  // lit pixels: the lv leftmost of LEVEL_MAX columns, masked to 5 bits
  function automatic logic [4:0] row_pattern(input logic [2:0] lv);
    logic [8:0] full;
    logic [8:0] dark;
    full = 9'((1 << LEVEL_MAX) - 1);
    dark = 9'((1 << (LEVEL_MAX - int'(lv))) - 1);
    return 5'(full & ~dark);
  endfunction

  function automatic logic [2:0] clamp(input logic [2:0] lv);
    return ({1'b0, lv} > LMAX4) ? LMAX3 : lv;
  endfunction

  function automatic logic [2:0] absdiff(input logic [2:0] x, input logic [2:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  // slot store
  logic             slot_written     [NUM_GLYPHS];
  logic [2:0]       slot_upper_level [NUM_GLYPHS];
  logic [2:0]       slot_lower_level [NUM_GLYPHS];
  logic [1:0]       slot_age         [NUM_GLYPHS];

  logic [2:0]       lvl_a, lvl_b;
  logic [IDX_W-1:0] cnt;
  logic             match_found, free_found, best_found;
  logic [IDX_W-1:0] match_idx, free_idx, best_idx;
  logic [3:0]       best_dist;

  // current slot under the scan
  logic             cur_written;
  logic [2:0]       cur_u, cur_l;
  logic [1:0]       cur_age;
  logic             cur_match, cur_free, cur_compat;
  logic [3:0]       cur_dist;
  logic             a_edge, b_edge;

  assign cur_written = slot_written[cnt];
  assign cur_u       = slot_upper_level[cnt];
  assign cur_l       = slot_lower_level[cnt];
  assign cur_age     = slot_age[cnt];

  assign a_edge     = (lvl_a == 3'd0) || ({1'b0, lvl_a} == LMAX4);
  assign b_edge     = (lvl_b == 3'd0) || ({1'b0, lvl_b} == LMAX4);
  assign cur_match  = cur_written && (cur_u == lvl_a) && (cur_l == lvl_b);
  assign cur_free   = (cur_age == 2'd0);
  assign cur_compat = cur_written && (!a_edge || cur_u == lvl_a) && (!b_edge || cur_l == lvl_b);
  assign cur_dist   = 4'(absdiff(cur_u, lvl_a)) + 4'(absdiff(cur_l, lvl_b));

  assign status.scan_last = (cnt == IDX_LAST);

  logic is_blank, is_full;
  assign is_blank = (lvl_a == 3'd0) && (lvl_b == 3'd0);
  assign is_full  = ({1'b0, lvl_a} == LMAX4) && ({1'b0, lvl_b} == LMAX4);

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lvl_a       <= clamp(item.left_level);
      lvl_b       <= clamp(item.right_level);
      cnt         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      best_found  <= 1'b0;
    end else if (cmd.scan_step || cmd.tick_step) begin
      cnt <= cnt + 1'b1;
      if (cmd.scan_step) begin
        if (cur_match && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= cnt;
        end
        if (cur_free && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cnt;
        end
        if (cur_compat && (!best_found || cur_dist < best_dist)) begin
          best_found <= 1'b1;
          best_idx   <= cnt;
          best_dist  <= cur_dist;
        end
      end
    end
  end

  // slot updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GLYPHS; i++) begin
        slot_written[i]     <= 1'b0;
        slot_upper_level[i] <= 3'd0;
        slot_lower_level[i] <= 3'd0;
        slot_age[i]         <= 2'd0;
      end
    end else if (cmd.tick_step) begin
      if (cur_age != 2'd0) begin
        slot_age[cnt] <= cur_age - 2'd1;
      end
    end else if (cmd.decide && !is_blank && !is_full) begin
      if (match_found) begin
        slot_age[match_idx] <= AGE_FRESH;
      end else if (free_found) begin
        slot_written[free_idx]     <= 1'b1;
        slot_upper_level[free_idx] <= lvl_a;
        slot_lower_level[free_idx] <= lvl_b;
        slot_age[free_idx]         <= AGE_FRESH;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.decide || cmd.tick_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_step) begin
      result.char_code     <= 8'(cnt);
      result.define_glyph  <= (cur_age == AGE_FRESH);
      result.upper_pattern <= row_pattern(cur_u);
      result.lower_pattern <= row_pattern(cur_l);
      result.no_match      <= 1'b0;
      result.last          <= (cnt == IDX_LAST);
    end else if (cmd.decide) begin
      result.define_glyph  <= 1'b0;
      result.upper_pattern <= 5'd0;
      result.lower_pattern <= 5'd0;
      result.last          <= 1'b1;
      result.no_match      <= 1'b0;
      if (is_blank) begin
        result.char_code <= CODE_BLANK;
      end else if (is_full) begin
        result.char_code <= CODE_FULL;
      end else if (match_found) begin
        result.char_code <= 8'(match_idx);
      end else if (free_found) begin
        result.char_code <= 8'(free_idx);
      end else if (best_found) begin
        result.char_code <= 8'(best_idx);
      end else begin
        result.char_code <= CODE_BLANK;
        result.no_match  <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/dual_bar_glyph_cache.sv
// Custom glyph cache for a character display showing two bar levels per cell.
// Input channel: drive item and pulse start; the beat is taken on a rising
//   edge where start is high and busy is low.
// item.func = lookup: the level pair is mapped to a character code. Blank and
//   solid pairs give the fixed codes; else an exact stored match is refreshed,
//   else a slot of age zero is claimed, else the closest compatible slot is
//   returned; with none, code 32 and no_match.
// item.func = tick: one result beat per slot, in slot order, carrying the slot
//   index, define_glyph and both row patterns; last marks the final beat.
// Result channel: result_strobe marks each beat for exactly one cycle. The
//   receiver cannot stall, so it must take every strobed beat.
// Timing: a lookup scans all slots once, one per cycle, then decides; busy is
//   high through both, and the result is registered and strobed in the cycle
//   after the decide. A tick emits one beat per cycle. Both rates are set by
//   the single slot read port that the scan counter drives.
// Reset (synchronous, active high) clears all slots: unwritten, levels and
//   ages zero, controller idle, no strobe.
module dual_bar_glyph_cache
  import dbgc_pkg::*;
#(
  parameter int NUM_GLYPHS = NUM_GLYPHS_DEF,
  parameter int LEVEL_MAX  = LEVEL_MAX_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  in_item_t item,
  output logic     result_strobe,
  output result_t  result
);

  cmd_t    cmd;
  status_t status;

  // sequencer: idle / scan / decide / tick
  dbgc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (item.func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // slot store, scan trackers and output register
  dbgc_dp #(
    .NUM_GLYPHS (NUM_GLYPHS),
    .LEVEL_MAX  (LEVEL_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .cmd           (cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule
